[sv/obl_pkg.sv]
`default_nettype none
package obl_pkg;

    localparam int LEVELS_DEF = 64;
    localparam int PRICE_W    = 32;
    localparam int VOL_W      = 40;
    localparam int POS_W      = 6;
    localparam int CNT_W      = 7;
    localparam int QDEPTH     = 2;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_DELETED  = 3'd2,
        ST_DEL_MISS = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef struct packed {
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   volume;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         status;
        logic [POS_W-1:0]   level_position;
        logic [CNT_W-1:0]   level_count;
        logic               side_empty;
        logic [PRICE_W-1:0] best_price;
        logic [VOL_W-1:0]   best_volume;
    } t_out_word;

    // classified command handed from front to back
    typedef struct packed {
        logic               side;
        logic               del;
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   volume;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MATCH,
        BK_OUT
    } t_bk_state;

endpackage
`default_nettype wire

[sv/obl_front.sv]
`default_nettype none
// Two-entry command queue towards the back end; classify each word on entry.
module obl_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire obl_pkg::t_in_word i_data,
    output logic                  o_cmd_valid,
    input  wire logic             i_cmd_ready,
    output obl_pkg::t_cmd         o_cmd
);
    obl_pkg::t_cmd r_q [obl_pkg::QDEPTH];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push, pop;
    obl_pkg::t_cmd cmd_in;

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        cmd_in.side   = i_data.side;
        cmd_in.del    = (i_data.volume == '0);
        cmd_in.price  = i_data.price;
        cmd_in.volume = i_data.volume;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

[sv/obl_side.sv]
`default_nettype none
// One side of the book as a row of compare-and-shift cells, best level in cell 0.
module obl_side #(
    parameter int LEVELS = obl_pkg::LEVELS_DEF,
    parameter bit ASK    = 1'b0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [obl_pkg::PRICE_W-1:0] i_price,
    input  wire logic                        i_cmp,
    input  wire logic                        i_ins,
    input  wire logic                        i_del,
    input  wire logic                        i_upd,
    input  wire logic [obl_pkg::VOL_W-1:0]   i_volume,
    output logic                             o_hit,
    output logic [$clog2(LEVELS+1)-1:0]      o_pos,
    output logic [$clog2(LEVELS+1)-1:0]      o_count,
    output logic [obl_pkg::PRICE_W-1:0]      o_best_price,
    output logic [obl_pkg::VOL_W-1:0]        o_best_volume
);
    localparam int CW = $clog2(LEVELS + 1);

    logic [obl_pkg::PRICE_W-1:0] r_price [LEVELS];
    logic [obl_pkg::VOL_W-1:0]   r_vol   [LEVELS];
    logic [LEVELS-1:0]           r_past, r_eq;
    logic [CW-1:0]               r_count;
    logic [LEVELS-1:0]           live, past_now, eq_now;

    // cell compares, registered so the update cycle only shifts or writes
    always_comb begin
        for (int k = 0; k < LEVELS; k++) begin
            live[k]     = (CW'(k) < r_count);
            past_now[k] = live[k] && (ASK ? (r_price[k] >= i_price)
                                          : (r_price[k] <= i_price));
            eq_now[k]   = live[k] && (r_price[k] == i_price);
        end
    end

    // past is thermometer coded: position is the count of cells still better
    always_comb begin
        o_pos = r_count - CW'($countones(r_past));
        o_hit = |r_eq;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmp) begin
            r_past <= past_now;
            r_eq   <= eq_now;
        end
        for (int k = 0; k < LEVELS; k++) begin
            if (i_upd && r_eq[k]) begin
                r_vol[k] <= i_volume;
            end
            if (i_ins) begin
                if (r_past[k] && k > 0 && r_past[k-1 < 0 ? 0 : k-1]) begin
                    r_price[k] <= r_price[k-1 < 0 ? 0 : k-1];
                    r_vol[k]   <= r_vol[k-1 < 0 ? 0 : k-1];
                end else if (k == 0 ? r_past[0] || !live[0]
                                    : (r_past[k] || !live[k]) && !r_past[k-1 < 0 ? 0 : k-1]
                                      && live[k-1 < 0 ? 0 : k-1]) begin
                    if (k == 0 || !r_past[k-1 < 0 ? 0 : k-1]) begin
                        r_price[k] <= i_price;
                        r_vol[k]   <= i_volume;
                    end
                end else if (!live[k] && k > 0 && r_past[k-1 < 0 ? 0 : k-1]
                             && live[k-1 < 0 ? 0 : k-1]) begin
                    r_price[k] <= r_price[k-1 < 0 ? 0 : k-1];
                    r_vol[k]   <= r_vol[k-1 < 0 ? 0 : k-1];
                end
            end
            if (i_del && k < LEVELS - 1) begin
                if (r_past[k]) begin
                    r_price[k] <= r_price[k+1 >= LEVELS ? k : k+1];
                    r_vol[k]   <= r_vol[k+1 >= LEVELS ? k : k+1];
                end
            end
        end
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ins) begin
            r_count <= r_count + CW'(1);
        end else if (i_del) begin
            r_count <= r_count - CW'(1);
        end
    end

    assign o_count       = r_count;
    assign o_best_price  = (r_count != '0) ? r_price[0] : '0;
    assign o_best_volume = (r_count != '0) ? r_vol[0]   : '0;
endmodule
`default_nettype wire

[sv/obl_back.sv]
`default_nettype none
// Back end: compare cycle, then apply cycle, then hold the result word.
module obl_back #(
    parameter int LEVELS = obl_pkg::LEVELS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_ready,
    input  wire obl_pkg::t_cmd  i_cmd,
    output logic                o_valid,
    input  wire logic           i_ready,
    output obl_pkg::t_out_word  o_data
);
    localparam int CW = $clog2(LEVELS + 1);

    obl_pkg::t_bk_state r_state, n_state;
    obl_pkg::t_cmd      r_cmd;
    logic [2:0]         r_status;
    logic [obl_pkg::POS_W-1:0] r_pos;
    logic               cmp, apply;
    logic               bid_hit, ask_hit, hit;
    logic [CW-1:0]      bid_pos, ask_pos, pos, bid_cnt, ask_cnt, cnt;
    logic [obl_pkg::PRICE_W-1:0] bid_bp, ask_bp;
    logic [obl_pkg::VOL_W-1:0]   bid_bv, ask_bv;
    logic               full, do_ins, do_del, do_upd;
    logic [2:0]         status;
    logic [CW-1:0]      rpos;

    assign cmp   = (r_state == obl_pkg::BK_IDLE) && i_cmd_valid;
    assign apply = (r_state == obl_pkg::BK_MATCH);

    assign hit  = r_cmd.side ? ask_hit : bid_hit;
    assign pos  = r_cmd.side ? ask_pos : bid_pos;
    assign cnt  = r_cmd.side ? ask_cnt : bid_cnt;
    assign full = (cnt == CW'(LEVELS));

    always_comb begin
        do_ins = 1'b0;
        do_del = 1'b0;
        do_upd = 1'b0;
        rpos   = '0;
        if (hit && !r_cmd.del) begin
            status = obl_pkg::ST_UPDATED;
            do_upd = apply;
            rpos   = pos;
        end else if (hit) begin
            status = obl_pkg::ST_DELETED;
            do_del = apply;
            rpos   = pos;
        end else if (r_cmd.del) begin
            status = obl_pkg::ST_DEL_MISS;
        end else if (full) begin
            status = obl_pkg::ST_FULL;
        end else begin
            status = obl_pkg::ST_INSERTED;
            do_ins = apply;
            rpos   = pos;
        end
    end

    obl_side #(.LEVELS(LEVELS), .ASK(1'b0)) u_bid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_price(cmp ? i_cmd.price : r_cmd.price),
        .i_cmp(cmp && !i_cmd.side), .i_ins(do_ins && !r_cmd.side),
        .i_del(do_del && !r_cmd.side), .i_upd(do_upd && !r_cmd.side),
        .i_volume(r_cmd.volume), .o_hit(bid_hit), .o_pos(bid_pos), .o_count(bid_cnt),
        .o_best_price(bid_bp), .o_best_volume(bid_bv)
    );

    obl_side #(.LEVELS(LEVELS), .ASK(1'b1)) u_ask (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_price(cmp ? i_cmd.price : r_cmd.price),
        .i_cmp(cmp && i_cmd.side), .i_ins(do_ins && r_cmd.side),
        .i_del(do_del && r_cmd.side), .i_upd(do_upd && r_cmd.side),
        .i_volume(r_cmd.volume), .o_hit(ask_hit), .o_pos(ask_pos), .o_count(ask_cnt),
        .o_best_price(ask_bp), .o_best_volume(ask_bv)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            obl_pkg::BK_IDLE:  if (i_cmd_valid) n_state = obl_pkg::BK_MATCH;
            obl_pkg::BK_MATCH: n_state = obl_pkg::BK_OUT;
            obl_pkg::BK_OUT:   if (i_ready) n_state = obl_pkg::BK_IDLE;
            default:           n_state = obl_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_ready = (r_state == obl_pkg::BK_IDLE);
        o_valid     = (r_state == obl_pkg::BK_OUT);
    end

    // best level is read after the apply edge, so the word is built there
    always_comb begin
        o_data.status         = r_status;
        o_data.level_position = r_pos;
        o_data.level_count    = r_cmd.side ? (obl_pkg::CNT_W)'(ask_cnt)
                                           : (obl_pkg::CNT_W)'(bid_cnt);
        o_data.side_empty     = r_cmd.side ? (ask_cnt == '0) : (bid_cnt == '0);
        o_data.best_price     = r_cmd.side ? ask_bp : bid_bp;
        o_data.best_volume    = r_cmd.side ? ask_bv : bid_bv;
    end

    always_ff @(posedge i_clk) begin
        if (cmp) begin
            r_cmd <= i_cmd;
        end
        if (apply) begin
            r_status <= status;
            r_pos    <= (obl_pkg::POS_W)'(rpos);
        end
        if (!i_rst_n) begin
            r_state <= obl_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

[sv/order_book_level_update.sv]
`default_nettype none
// Two-sided price-level book: bids best-high, asks best-low, LEVELS cells a side.
// An update passes the back end in order (compare across the cell row, shift or
// overwrite, hand out the result); a two-word queue in front keeps input open
// while the back end works or the result waits. The back end takes no new
// command until its result word has been accepted.
module order_book_level_update #(
    parameter int LEVELS = obl_pkg::LEVELS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire obl_pkg::t_in_word  i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output obl_pkg::t_out_word      o_data
);
    logic          cmd_valid, cmd_ready;
    obl_pkg::t_cmd cmd;

    obl_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    obl_back #(.LEVELS(LEVELS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid),
        .o_cmd_ready(cmd_ready), .i_cmd(cmd), .o_valid(o_valid),
        .i_ready(i_ready), .o_data(o_data)
    );
endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;

    localparam int NLEV      = obl_pkg::LEVELS_DEF;
    localparam int MAX_CYC   = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    obl_pkg::t_in_word  i_data = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    obl_pkg::t_out_word o_data;

    order_book_level_update dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #10 i_clk = ~i_clk;

    // book model
    logic [obl_pkg::PRICE_W-1:0] bk_px [2][NLEV];
    logic [obl_pkg::VOL_W-1:0]   bk_vol [2][NLEV];
    int                          bk_cnt [2];

    obl_pkg::t_in_word  pending_words[$];
    obl_pkg::t_out_word expected_words[$];
    int        errors = 0;
    int        cycles = 0;
    int        accepted = 0;
    int        received = 0;
    bit        calm = 1'b0;
    int        tx_gap = 0;
    int        rx_gap = 0;
    int        st_seen [8];

    function automatic obl_pkg::t_out_word book_apply(obl_pkg::t_in_word w);
        obl_pkg::t_out_word r;
        int s, n, pos, i;
        bit past;
        s = w.side;
        n = bk_cnt[s];
        pos = 0;
        r = '0;
        while (pos < n) begin
            past = s ? (bk_px[s][pos] >= w.price) : (bk_px[s][pos] <= w.price);
            if (past) break;
            pos++;
        end
        if (pos < n && bk_px[s][pos] == w.price) begin
            if (w.volume != 0) begin
                bk_vol[s][pos] = w.volume;
                r.status = obl_pkg::ST_UPDATED;
            end else begin
                for (i = pos; i + 1 < n; i++) begin
                    bk_px[s][i] = bk_px[s][i+1];
                    bk_vol[s][i] = bk_vol[s][i+1];
                end
                n--;
                r.status = obl_pkg::ST_DELETED;
            end
        end else if (w.volume == 0) begin
            r.status = obl_pkg::ST_DEL_MISS;
            pos = 0;
        end else if (n >= NLEV) begin
            r.status = obl_pkg::ST_FULL;
            pos = 0;
        end else begin
            for (i = n; i > pos; i--) begin
                bk_px[s][i] = bk_px[s][i-1];
                bk_vol[s][i] = bk_vol[s][i-1];
            end
            bk_px[s][pos] = w.price;
            bk_vol[s][pos] = w.volume;
            n++;
            r.status = obl_pkg::ST_INSERTED;
        end
        bk_cnt[s] = n;
        r.level_position = pos[obl_pkg::POS_W-1:0];
        r.level_count = n[obl_pkg::CNT_W-1:0];
        r.side_empty = (n == 0);
        r.best_price = (n != 0) ? bk_px[s][0] : '0;
        r.best_volume = (n != 0) ? bk_vol[s][0] : '0;
        return r;
    endfunction

    function automatic obl_pkg::t_in_word mk(bit s, logic [31:0] p, logic [39:0] v);
        obl_pkg::t_in_word w;
        w.side = s;
        w.price = p;
        w.volume = v;
        return w;
    endfunction

    function automatic void queue_word(obl_pkg::t_in_word w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    function automatic logic [39:0] rand_vol();
        logic [63:0] wide;
        logic [39:0] v;
        wide = {$urandom, $urandom};
        v = wide[39:0];
        case ($urandom_range(0, 3))
            0: v = 40'($urandom_range(1, 100));
            1: v = 40'hFF_FFFF_FFFF;
            default: ;
        endcase
        return v;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_words.insert(expected_words.size(), book_apply(i_data));
                accepted++;
            end
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    i_data <= pending_words.pop_front();
                    i_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0) tx_gap <= $urandom_range(1, 6);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                received++;
                if (expected_words.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected word %h", o_data);
                end else begin
                    obl_pkg::t_out_word e;
                    e = expected_words.pop_front();
                    st_seen[e.status]++;
                    if (e !== o_data) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: exp st=%0d pos=%0d cnt=%0d emp=%0d px=%h vol=%h",
                                e.status, e.level_position, e.level_count, e.side_empty,
                                e.best_price, e.best_volume);
                            $display("          act st=%0d pos=%0d cnt=%0d emp=%0d px=%h vol=%h",
                                o_data.status, o_data.level_position, o_data.level_count,
                                o_data.side_empty, o_data.best_price, o_data.best_volume);
                        end
                    end
                end
            end
            if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                rx_gap <= $urandom_range(0, 5);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int k, j, lo;
        bit s;
        logic [31:0] base;
        bk_cnt[0] = 0;
        bk_cnt[1] = 0;
        // directed: extremes, each status, duplicates, filling a side
        queue_word(mk(0, 32'd100, 40'd0));
        queue_word(mk(1, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF));
        queue_word(mk(1, 32'd0, 40'd1));
        queue_word(mk(1, 32'hFFFF_FFFF, 40'd5));
        queue_word(mk(0, 32'd0, 40'hFF_FFFF_FFFF));
        queue_word(mk(0, 32'hFFFF_FFFF, 40'd7));
        queue_word(mk(0, 32'h8000_0000, 40'h55_5555_5555));
        queue_word(mk(0, 32'h8000_0000, 40'hAA_AAAA_AAAA));
        queue_word(mk(0, 32'hFFFF_FFFF, 40'd0));
        queue_word(mk(0, 32'h1234, 40'd0));
        queue_word(mk(1, 32'd0, 40'd0));
        queue_word(mk(1, 32'hFFFF_FFFF, 40'd0));
        queue_word(mk(1, 32'd50, 40'd0));
        for (k = 0; k < 66; k++) queue_word(mk(1, 32'(1000 + k * 3), 40'(9 + k)));
        queue_word(mk(1, 32'd1001, 40'd3));
        queue_word(mk(1, 32'd1000, 40'd0));
        // random: walks around a price window, wide noise, occasional side flushes
        for (k = 0; k < 1600; k++) begin
            s = 1'($urandom_range(0, 1));
            lo = $urandom_range(0, 9);
            if (lo == 0) base = $urandom;
            else if (lo == 1) base = ($urandom_range(0, 1) != 0)
                                     ? 32'hFFFF_FFFF - 32'($urandom_range(0, 40))
                                     : 32'($urandom_range(0, 40));
            else base = 32'd5000 + 32'($urandom_range(0, 90));
            if ($urandom_range(0, 2) == 0)
                queue_word(mk(s, base, 40'd0));
            else
                queue_word(mk(s, base, rand_vol()));
            if (k % 400 == 399)
                for (j = 5000; j <= 5090; j++) queue_word(mk(s, 32'(j), 40'd0));
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_words.size() < 200);
        calm = 1'b1;
        wait (pending_words.size() == 0 && !i_valid);
        wait (expected_words.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("%0d updates sent, %0d results checked", accepted, received);
        $display("status mix upd/ins/del/miss/full: %0d/%0d/%0d/%0d/%0d",
            st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4]);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

[order_book_level_update.f]
sv/obl_pkg.sv
sv/obl_front.sv
sv/obl_side.sv
sv/obl_back.sv
sv/order_book_level_update.sv
tb/tb.sv
